// ===== hdl/pidc_pkg.sv =====
// Shared types and constants for the PID position controller.
// Used by pidc_ctrl, pidc_datapath and the pid_position_controller top level.
package pidc_pkg;

  // Field widths.
  localparam int POS_W    = 24;  // Q16.8 positions, limits and drive
  localparam int GAIN_W   = 16;  // unsigned Q8.8 gains
  localparam int ERR_W    = 25;  // target minus measurement
  localparam int INTEG_W  = 16;  // signed Q8.8 integral
  localparam int DERIV_W  = 31;  // measurement delta times 50
  localparam int MUL_B_W  = 31;  // widest operand of the gain multiplier
  localparam int PROD_W   = 48;  // gain times operand, Q.16
  localparam int TERM_W   = 40;  // one product floored to Q.8
  localparam int ACC_W    = 42;  // sum of three terms
  localparam int DIV_U_W  = 26;  // biased dividend for the divide by 50
  localparam int RECIP_W  = 27;
  localparam int DIV_P_W  = DIV_U_W + RECIP_W;
  localparam int DIV_Q_W  = 20;
  localparam int INTSUM_W = 22;
  localparam int IDX_W    = 3;

  // Divide by 50: bias the dividend by 50 * 2^19 so that it is never negative,
  // multiply by floor(2^32 / 50), then correct the quotient by at most one.
  localparam logic [RECIP_W-1:0]  RECIP_50 = 27'd85899345;
  localparam logic [RECIP_W-1:0]  DIV_BIAS = 27'd26214400;
  localparam logic [DIV_Q_W:0]    Q_BIAS   = 21'd524288;
  localparam logic [DIV_U_W-1:0]  DIVISOR  = 26'd50;

  localparam logic signed [INTSUM_W-1:0] INTEG_LIMIT = 22'sd12800;
  localparam logic signed [INTEG_W-1:0]  INTEG_MAX   = 16'sd12800;
  localparam logic signed [INTEG_W-1:0]  INTEG_MIN   = -16'sd12800;
  localparam logic signed [POS_W-1:0]    MIN_MAG     = 24'sd7680;

  localparam logic signed [POS_W-1:0] OUT_MIN_RST = -24'sd32512;
  localparam logic signed [POS_W-1:0] OUT_MAX_RST = 24'sd32512;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4
  } pidc_reg_e;

  typedef enum logic [1:0] {
    MUL_P = 2'd0,
    MUL_I = 2'd1,
    MUL_D = 2'd2
  } pidc_mul_sel_e;

  typedef struct packed {
    logic          load;       // capture the item
    logic          div_mul;    // reciprocal multiply, derivative scale
    logic          div_fix;    // quotient correction
    logic          integ_upd;  // integral update and clamp
    logic          prod_en;    // gain multiplier result register enable
    pidc_mul_sel_e mul_sel;
    logic          acc_init;   // accumulator takes the first term
    logic          acc_add;    // accumulator adds a term
    logic          res_load;   // output register takes the result
  } pidc_cmd_t;

endpackage

// ===== hdl/pidc_ctrl.sv =====
// Sequencer for the PID step: walks the datapath through one item.
// Depends on pidc_pkg for the command struct.
module pidc_ctrl import pidc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output pidc_cmd_t cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_FIX  = 7'b0000100,
    S_INT  = 7'b0001000,
    S_MULI = 7'b0010000,
    S_ACCI = 7'b0100000,
    S_OUT  = 7'b1000000
  } pidc_state_e;

  pidc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_P;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_mul = 1'b1;
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = MUL_P;
        state_d       = S_FIX;
      end
      S_FIX: begin
        cmd_o.div_fix  = 1'b1;
        cmd_o.prod_en  = 1'b1;
        cmd_o.mul_sel  = MUL_D;
        cmd_o.acc_init = 1'b1;
        state_d        = S_INT;
      end
      S_INT: begin
        cmd_o.integ_upd = 1'b1;
        cmd_o.acc_add   = 1'b1;
        state_d         = S_MULI;
      end
      S_MULI: begin
        cmd_o.prod_en = 1'b1;
        cmd_o.mul_sel = MUL_I;
        state_d       = S_ACCI;
      end
      S_ACCI: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending result");

  // An accepted item always starts the divide step next.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DIV))
    else $error("accepted item did not start the sequence");

  // Delivering a result frees the input side in the next cycle.
  a_ready_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> (in_ready_o && out_valid_o))
    else $error("block not ready after a result was loaded");

endmodule

// ===== hdl/pidc_datapath.sv =====
// Arithmetic for the PID step: error, divide by 50, integral, derivative,
// shared gain multiplier, accumulator, clamp and lift. Depends on pidc_pkg.
module pidc_datapath import pidc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pidc_cmd_t               cmd_i,
  input  logic signed [POS_W-1:0] target_pos_i,
  input  logic signed [POS_W-1:0] measured_pos_i,
  input  logic                    restart_i,
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [POS_W-1:0]        cfg_data_i,
  output logic signed [POS_W-1:0] drive_o,
  output logic                    clamped_o
);

  // Configuration and controller state.
  logic [GAIN_W-1:0]         gain_p_q, gain_i_q, gain_d_q;
  logic signed [POS_W-1:0]   out_min_q, out_max_q;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [POS_W-1:0]   prev_q;

  // Working registers.
  logic signed [ERR_W-1:0]   err_q, dmeas_q;
  logic signed [DERIV_W-1:0] deriv_q;
  logic [DIV_Q_W-1:0]        div_hi_q, quot_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [POS_W-1:0]   drive_q;
  logic                      clamped_q;

  // Item capture.
  logic signed [POS_W-1:0] prev_eff;
  logic signed [ERR_W-1:0] err_d, dmeas_d;

  assign prev_eff = restart_i ? '0 : prev_q;
  assign err_d    = {target_pos_i[POS_W-1], target_pos_i}
                  - {measured_pos_i[POS_W-1], measured_pos_i};
  assign dmeas_d  = {measured_pos_i[POS_W-1], measured_pos_i}
                  - {prev_eff[POS_W-1], prev_eff};

  // Divide by 50 with floor.
  logic [RECIP_W-1:0] div_u_sum;
  logic [DIV_U_W-1:0] div_u, q0_x50, div_rem;
  logic [DIV_P_W-1:0] div_prod;
  logic               div_corr;

  assign div_u_sum = {{(RECIP_W-ERR_W){err_q[ERR_W-1]}}, err_q} + DIV_BIAS;
  assign div_u     = div_u_sum[DIV_U_W-1:0];
  assign div_prod  = {{RECIP_W{1'b0}}, div_u} * {{DIV_U_W{1'b0}}, RECIP_50};
  assign q0_x50    = ({{(DIV_U_W-DIV_Q_W){1'b0}}, div_hi_q} << 5)
                   + ({{(DIV_U_W-DIV_Q_W){1'b0}}, div_hi_q} << 4)
                   + ({{(DIV_U_W-DIV_Q_W){1'b0}}, div_hi_q} << 1);
  assign div_rem   = div_u - q0_x50;
  assign div_corr  = (div_rem >= DIVISOR);

  // Derivative scale by 50.
  logic [DERIV_W-1:0] dm_ext, deriv_d;

  assign dm_ext  = {{(DERIV_W-ERR_W){dmeas_q[ERR_W-1]}}, dmeas_q};
  assign deriv_d = (dm_ext << 5) + (dm_ext << 4) + (dm_ext << 1);

  // Integral update and clamp.
  logic signed [DIV_Q_W:0]    quot_s;
  logic signed [INTSUM_W-1:0] integ_sum;

  assign quot_s    = $signed({1'b0, quot_q}) - $signed(Q_BIAS);
  assign integ_sum = {{(INTSUM_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}
                   + {quot_s[DIV_Q_W], quot_s};

  always_comb begin
    if (integ_sum > INTEG_LIMIT) begin
      integ_d = INTEG_MAX;
    end else if (integ_sum < -INTEG_LIMIT) begin
      integ_d = INTEG_MIN;
    end else begin
      integ_d = integ_sum[INTEG_W-1:0];
    end
  end

  // Shared gain multiplier: unsigned gain times signed operand.
  logic [GAIN_W-1:0]         mul_gain;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_a_ext, mul_b_ext, mul_prod;
  logic signed [ACC_W-1:0]   term_ext;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P: begin
        mul_gain = gain_p_q;
        mul_b    = {{(MUL_B_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      MUL_I: begin
        mul_gain = gain_i_q;
        mul_b    = {{(MUL_B_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
      end
      MUL_D: begin
        mul_gain = gain_d_q;
        mul_b    = deriv_q;
      end
      default: begin
        mul_gain = '0;
        mul_b    = '0;
      end
    endcase
  end

  assign mul_a_ext = {{(PROD_W-GAIN_W){1'b0}}, mul_gain};
  assign mul_b_ext = {{(PROD_W-MUL_B_W){mul_b[MUL_B_W-1]}}, mul_b};
  assign mul_prod  = mul_a_ext * mul_b_ext;
  // Dropping the eight fraction bits of a two's complement value floors it.
  assign term_ext  = {{(ACC_W-TERM_W){prod_q[PROD_W-1]}}, prod_q[PROD_W-1:PROD_W-TERM_W]};

  // Output clamp, then the minimum magnitude lift.
  logic signed [ACC_W-1:0] max_ext, min_ext, clip_hi_val, clip_val;
  logic                    over_max, under_min;
  logic signed [POS_W-1:0] val, lifted;

  assign max_ext     = {{(ACC_W-POS_W){out_max_q[POS_W-1]}}, out_max_q};
  assign min_ext     = {{(ACC_W-POS_W){out_min_q[POS_W-1]}}, out_min_q};
  assign over_max    = (acc_q > max_ext);
  assign clip_hi_val = over_max ? max_ext : acc_q;
  assign under_min   = (clip_hi_val < min_ext);
  assign clip_val    = under_min ? min_ext : clip_hi_val;
  assign val         = clip_val[POS_W-1:0];

  // The sign bit tells positive from negative; zero passes through untouched.
  always_comb begin
    if (!val[POS_W-1] && val != '0 && val < MIN_MAG) begin
      lifted = MIN_MAG;
    end else if (val[POS_W-1] && val > -MIN_MAG) begin
      lifted = -MIN_MAG;
    end else begin
      lifted = val;
    end
  end

  // State with a reset value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      out_min_q <= OUT_MIN_RST;
      out_max_q <= OUT_MAX_RST;
      integ_q   <= '0;
      prev_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_P:  gain_p_q  <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_I:  gain_i_q  <= cfg_data_i[GAIN_W-1:0];
          REG_GAIN_D:  gain_d_q  <= cfg_data_i[GAIN_W-1:0];
          REG_OUT_MIN: out_min_q <= cfg_data_i;
          REG_OUT_MAX: out_max_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.load) begin
        prev_q <= measured_pos_i;
        if (restart_i) begin
          integ_q <= '0;
        end
      end else if (cmd_i.integ_upd) begin
        integ_q <= integ_d;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q   <= err_d;
      dmeas_q <= dmeas_d;
    end
    if (cmd_i.div_mul) begin
      div_hi_q <= div_prod[DIV_P_W-2:DIV_P_W-1-DIV_Q_W];
      deriv_q  <= deriv_d;
    end
    if (cmd_i.div_fix) begin
      quot_q <= div_hi_q + {{(DIV_Q_W-1){1'b0}}, div_corr};
    end
    if (cmd_i.prod_en) begin
      prod_q <= mul_prod;
    end
    if (cmd_i.acc_init) begin
      acc_q <= term_ext;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + term_ext;
    end
    if (cmd_i.res_load) begin
      drive_q   <= lifted;
      clamped_q <= over_max || under_min;
    end
  end

  assign drive_o   = drive_q;
  assign clamped_o = clamped_q;

  // The integral never leaves its +/-50.0 band.
  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= INTEG_MAX) && (integ_q >= INTEG_MIN))
    else $error("integral outside its clamp band");

  // The reciprocal estimate is off by at most one quotient step.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_fix |-> (div_rem < (DIVISOR << 1)))
    else $error("divide by 50 remainder out of range");

  // A loaded drive is zero or at least the minimum magnitude.
  a_drive_lift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> (drive_q == '0 || drive_q >= MIN_MAG || drive_q <= -MIN_MAG))
    else $error("drive below minimum magnitude");

endmodule

// ===== hdl/pid_position_controller.sv =====
// Top level of the PID position controller.
// Instantiates pidc_ctrl and pidc_datapath; depends on pidc_pkg.

// One item is one control tick: a target and a measured position in signed
// Q16.8 and a restart flag that clears the integral and the stored measurement
// before the step. Each item yields exactly one result: the drive value, clamped
// to [out_min, out_max] and then lifted to +/-30.0 when it is nonzero but smaller
// than that, plus a flag that tells whether the clamp acted. The sequence from
// acceptance until the result sits in the output register is set by the single
// shared gain multiplier, which serves the proportional, derivative and integral
// terms in turn, and by the divide by 50 (reciprocal multiply, then a one-step
// correction) that feeds the integral. The next item is accepted in the cycle
// after a result is loaded, even if that result has not yet been taken; a third
// item waits until the output register is free again, so the block works on one
// item at a time and takes no new item before the last result is loaded. Gains
// and limits are written through the configuration port; the user must write
// them only while the block is idle, a duty the block itself has no check for.
// A write to an unknown index is ignored.
module pid_position_controller import pidc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Input channel.
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [POS_W-1:0] target_pos_i,
  input  logic signed [POS_W-1:0] measured_pos_i,
  input  logic                    restart_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [POS_W-1:0] drive_o,
  output logic                    clamped_o,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [IDX_W-1:0]        cfg_idx_i,
  input  logic [POS_W-1:0]        cfg_data_i
);

  pidc_cmd_t cmd;

  // The sequencer owns the handshakes and the output valid flag.
  pidc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the gains, limits, controller state and result payload.
  pidc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .target_pos_i   (target_pos_i),
    .measured_pos_i (measured_pos_i),
    .restart_i      (restart_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .drive_o        (drive_o),
    .clamped_o      (clamped_o)
  );

endmodule
